/* design/bfrxc_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants of the bus frame receiver with XOR check.
// Used by every module of the block; depends on nothing.
package bfrxc_pkg;

  localparam int STORE_DEPTH_DEF = 256;
  localparam logic [7:0] IDLE_TIMEOUT_RST = 8'd8;
  localparam int MIN_FRAME_CNT = 4;

  // Action codes of an input word
  localparam logic [1:0] ACT_BYTE = 2'd0;
  localparam logic [1:0] ACT_TICK = 2'd1;
  localparam logic [1:0] ACT_SENT = 2'd2;
  localparam logic [1:0] ACT_READ = 2'd3;

  typedef enum logic [1:0] {
    OP_BYTE,
    OP_TICK,
    OP_ECHO,
    OP_READ
  } op_t;

  typedef enum logic [2:0] {
    EV_NONE     = 3'd0,
    EV_VALID    = 3'd1,
    EV_BAD_SUM  = 3'd2,
    EV_TIMEOUT  = 3'd3,
    EV_OVERFLOW = 3'd4,
    EV_ECHO     = 3'd5,
    EV_READ     = 3'd6
  } event_t;

  typedef struct packed {
    logic [1:0] action;
    logic [7:0] data_byte;
    logic [8:0] echo_count;
    logic [7:0] read_index;
  } in_word_t;

  typedef struct packed {
    logic [2:0] event_res;
    logic       frame_ready;
    logic [7:0] byte_count;
    logic [7:0] read_byte;
  } out_word_t;

  // Classified word as it sits in the queue
  typedef struct packed {
    op_t        op;
    logic [8:0] arg;
    logic       oob;
  } q_entry_t;

  typedef struct packed {
    logic     valid;
    q_entry_t entry;
  } q_head_t;

endpackage

/* design/bfrxc_front.sv */
`timescale 1ns / 1ps
// Front end: accepts input words and classifies them into queue entries.
// Depends on bfrxc_pkg.
module bfrxc_front import bfrxc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic     in_valid,
  output logic     in_stall,
  input  in_word_t in_word,
  input  logic     q_full,
  output logic     push,
  output q_entry_t entry
);

  assign in_stall = q_full;
  assign push     = in_valid && !q_full;

  always_comb begin
    entry.arg = 9'd0;
    entry.oob = 1'b0;
    unique case (in_word.action)
      ACT_BYTE: begin
        entry.op  = OP_BYTE;
        entry.arg = {1'b0, in_word.data_byte};
      end
      ACT_TICK: begin
        entry.op = OP_TICK;
      end
      ACT_SENT: begin
        entry.op  = OP_ECHO;
        entry.arg = in_word.echo_count;
      end
      ACT_READ: begin
        entry.op  = OP_READ;
        entry.arg = {1'b0, in_word.read_index};
        // flag indexes past the end of the store: they read as zero
        entry.oob = {1'b0, in_word.read_index} >= 9'(STORE_DEPTH);
      end
      default: begin
        entry.op = OP_TICK;
      end
    endcase
  end

endmodule

/* design/bfrxc_queue.sv */
`timescale 1ns / 1ps
// Two-entry queue between front end and back end.
// Depends on bfrxc_pkg.
module bfrxc_queue import bfrxc_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     push,
  input  q_entry_t push_entry,
  output logic     full,
  input  logic     pop,
  output q_head_t  head
);

  q_entry_t   slot_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] fill_r, fill_nxt;

  assign full       = fill_r == 2'd2;
  assign head.valid = fill_r != 2'd0;
  assign head.entry = slot_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = pop ? !rd_ptr_r : rd_ptr_r;
    fill_nxt   = fill_r + {1'b0, push} - {1'b0, pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      fill_r   <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      fill_r   <= fill_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_entry;
    end
  end

`ifndef SYNTHESIS
  a_no_overfill: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r != 2'd3)
    else $error("queue fill beyond two entries");
  a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
    full |-> !push)
    else $error("push into full queue");
  a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> head.valid)
    else $error("pop from empty queue");
`endif

endmodule

/* design/bfrxc_back.sv */
`timescale 1ns / 1ps
// Back end: frame state, frame store memory, timeout register and result register.
// Depends on bfrxc_pkg.
module bfrxc_back import bfrxc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  q_head_t    head,
  output logic       pop,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word
);

  localparam int AW = $clog2(STORE_DEPTH);
  localparam logic [AW-1:0] FULL_CNT = AW'(STORE_DEPTH - 1);
  localparam logic [AW-1:0] MIN_CNT  = AW'(MIN_FRAME_CNT);

  logic [7:0] mem [STORE_DEPTH];

  logic [AW-1:0] cnt_r, cnt_nxt;
  logic [7:0]    xor_r, xor_nxt;
  logic          held_r, held_nxt;
  logic [7:0]    idle_r, idle_nxt;
  logic [8:0]    echo_r, echo_nxt;
  logic [7:0]    len_r, len_nxt;
  logic [7:0]    timeout_r;

  logic          out_valid_r, out_valid_nxt;
  event_t        out_ev_r, ev;
  logic          out_ready_r;
  logic [AW-1:0] out_cnt_r;
  logic          out_rd_r;
  logic [7:0]    rdata_r;

  logic [7:0]    idle_pre;
  logic [AW-1:0] pc_cnt;
  logic [7:0]    pc_xor;
  logic          pc_held;
  event_t        pc_ev;
  logic          we;
  logic          re;
  logic [AW-1:0] waddr;

  assign pop = head.valid && (!out_valid_r || !out_stall);

  // Housekeeping ahead of a byte or tick: release, overflow, timeout
  always_comb begin
    idle_pre = idle_r;
    if (head.entry.op == OP_TICK && idle_r != 8'hFF) begin
      idle_pre = idle_r + 8'd1;
    end
    pc_cnt  = cnt_r;
    pc_xor  = xor_r;
    pc_held = held_r;
    pc_ev   = EV_NONE;
    if (held_r) begin
      pc_cnt  = '0;
      pc_xor  = 8'd0;
      pc_held = 1'b0;
    end
    if (pc_cnt >= FULL_CNT) begin
      pc_cnt  = '0;
      pc_xor  = 8'd0;
      pc_held = 1'b0;
      pc_ev   = EV_OVERFLOW;
    end
    if (pc_cnt != '0 && idle_pre >= timeout_r) begin
      pc_cnt  = '0;
      pc_xor  = 8'd0;
      pc_held = 1'b0;
      pc_ev   = EV_TIMEOUT;
    end
  end

  always_comb begin
    cnt_nxt  = cnt_r;
    xor_nxt  = xor_r;
    held_nxt = held_r;
    idle_nxt = idle_r;
    echo_nxt = echo_r;
    len_nxt  = len_r;
    ev       = EV_NONE;
    we       = 1'b0;
    re       = 1'b0;
    waddr    = pc_cnt;
    if (pop) begin
      unique case (head.entry.op)
        OP_BYTE: begin
          cnt_nxt  = pc_cnt;
          xor_nxt  = pc_xor;
          held_nxt = pc_held;
          ev       = pc_ev;
          if (echo_r != 9'd0) begin
            echo_nxt = echo_r - 9'd1;
            ev       = EV_ECHO;
          end else begin
            we      = 1'b1;
            cnt_nxt = pc_cnt + AW'(1);
            xor_nxt = pc_xor ^ head.entry.arg[7:0];
            if (pc_cnt == AW'(1)) begin
              len_nxt = head.entry.arg[7:0];
            end
          end
          idle_nxt = 8'd0;
          // frame complete: keep it if the XOR closes to zero, else drop
          if (cnt_nxt > MIN_CNT && ({1'b0, len_r} + 9'd2) == 9'(cnt_nxt)) begin
            if (xor_nxt == 8'd0) begin
              held_nxt = 1'b1;
              ev       = EV_VALID;
            end else begin
              cnt_nxt  = '0;
              xor_nxt  = 8'd0;
              held_nxt = 1'b0;
              ev       = EV_BAD_SUM;
            end
          end
        end
        OP_TICK: begin
          idle_nxt = idle_pre;
          cnt_nxt  = pc_cnt;
          xor_nxt  = pc_xor;
          held_nxt = pc_held;
          ev       = pc_ev;
        end
        OP_ECHO: begin
          echo_nxt = head.entry.arg;
        end
        OP_READ: begin
          re = !head.entry.oob;
          ev = EV_READ;
        end
        default: begin
          ev = EV_NONE;
        end
      endcase
    end
  end

  always_comb begin
    if (pop) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && out_stall;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r       <= '0;
      xor_r       <= 8'd0;
      held_r      <= 1'b0;
      idle_r      <= 8'd0;
      echo_r      <= 9'd0;
      timeout_r   <= IDLE_TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      cnt_r       <= cnt_nxt;
      xor_r       <= xor_nxt;
      held_r      <= held_nxt;
      idle_r      <= idle_nxt;
      echo_r      <= echo_nxt;
      out_valid_r <= out_valid_nxt;
      if (cfg_we) begin
        timeout_r <= cfg_wdata;
      end
    end
  end

  // Payload registers: loaded with each executed word
  always_ff @(posedge clk) begin
    len_r <= len_nxt;
    if (pop) begin
      out_ev_r    <= ev;
      out_ready_r <= held_nxt;
      out_cnt_r   <= cnt_nxt;
      out_rd_r    <= re;
    end
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= head.entry.arg[7:0];
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[head.entry.arg[AW-1:0]];
    end
  end

  assign out_valid            = out_valid_r;
  assign out_word.event_res   = out_ev_r;
  assign out_word.frame_ready = out_ready_r;
  assign out_word.byte_count  = 8'(out_cnt_r);
  assign out_word.read_byte   = out_rd_r ? rdata_r : 8'd0;

`ifndef SYNTHESIS
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FULL_CNT)
    else $error("stored count past end of store");
  a_held_sum: assert property (@(posedge clk) disable iff (!rst_n)
    held_r |-> (xor_r == 8'd0 && cnt_r > MIN_CNT))
    else $error("held frame with nonzero checksum or short length");
  a_pop_room: assert property (@(posedge clk) disable iff (!rst_n)
    pop |=> out_valid_r)
    else $error("executed word lost its result");
  a_idle_reset: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && head.entry.op == OP_BYTE) |=> idle_r == 8'd0)
    else $error("idle count not restarted by a byte");
`endif

endmodule

/* design/bus_frame_receiver_xor_check_unit.sv */
`timescale 1ns / 1ps
// Bus frame receiver with XOR checksum: top level.
// Depends on bfrxc_pkg, bfrxc_front, bfrxc_queue and bfrxc_back.
//
// Usage:
//   in_valid / in_stall / in_word carry one word per event: a received bus
//   byte, a one-millisecond tick, an own-frame-sent notice (echo count) or a
//   store read. A word is taken on a rising edge with in_valid high and
//   in_stall low. Every word yields exactly one result word on out_valid /
//   out_stall / out_word: event code, frame-ready flag, byte count and the
//   read byte.
//   cfg_we / cfg_wdata write the idle timeout in ticks (reset value 8); write
//   it only while no word is in flight.
// Timing: an accepted word passes through the queue and is executed into the
//   output register, which raises out_valid. One word per cycle is sustained
//   while out_stall stays low (running XOR, one store write port and one read port).
// Reset (rst_n low, synchronous) empties the queue and output register and
//   clears count, XOR, held flag, idle and echo counters. The frame store
//   itself is not cleared; read only positions written since reset.
// Stall: while out_stall is high and a result is waiting, the result holds,
//   execution pauses, the two-entry queue fills and then in_stall rises.
module bus_frame_receiver_xor_check_unit import bfrxc_pkg::*; #(
  parameter int STORE_DEPTH = STORE_DEPTH_DEF
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_valid,
  output logic       in_stall,
  input  in_word_t   in_word,
  output logic       out_valid,
  input  logic       out_stall,
  output out_word_t  out_word,
  input  logic       cfg_we,
  input  logic [7:0] cfg_wdata
);

  logic     q_full;
  logic     push;
  q_entry_t entry;
  logic     pop;
  q_head_t  head;

  // Classify the incoming word
  bfrxc_front #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .q_full   (q_full),
    .push     (push),
    .entry    (entry)
  );

  // Decouple acceptance from execution
  bfrxc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_entry (entry),
    .full       (q_full),
    .pop        (pop),
    .head       (head)
  );

  // Execute against frame state and store, register the result
  bfrxc_back #(
    .STORE_DEPTH(STORE_DEPTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .head      (head),
    .pop       (pop),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

endmodule

/* dv/tb_bus_frame_receiver_xor_check_unit.sv */
`timescale 1ns / 1ps
// Self-checking testbench of bus_frame_receiver_xor_check_unit: frames, ticks, echo skips
// and store reads are checked word by word against a predictor built into this file.
// Depends on bfrxc_pkg and the RTL of the block; needs nothing else.
module tb_bus_frame_receiver_xor_check_unit;
  import bfrxc_pkg::*;

  localparam int DEPTH        = STORE_DEPTH_DEF;
  // The store never fills its last position, so reads stay at or below this index
  localparam int READ_MAX     = DEPTH - 2;
  localparam int IDLE_MAX     = 255;
  localparam int HOLD_CYCLES  = 80;
  localparam int QUIET_LIMIT  = 5000;
  localparam int DRAIN_CYCLES = 4;

  logic      clk       = 1'b0;
  logic      rst_n     = 1'b0;
  logic      in_valid  = 1'b0;
  logic      in_stall;
  in_word_t  in_word   = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;
  logic      cfg_we    = 1'b0;
  logic [7:0] cfg_wdata = '0;

  // Words waiting to be driven, and results owed by the block in order
  in_word_t  bus_words_todo[$];
  out_word_t frame_events_due[$];

  // Pacing knobs set per phase by the stimulus process
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  bit hold_go      = 1'b0;
  logic rx_hold    = 1'b0;

  int err_cnt      = 0;
  int words_queued = 0;
  int words_taken  = 0;
  int stall_cycles = 0;
  int quiet_cycles = 0;
  int ev_tally[8]  = '{default: 0};
  int mid_tmo      = 0;

  // Predictor state: a shadow of the frame store and the receive counters
  logic [7:0] frame_mem[DEPTH];
  int         fill_cnt;
  logic [7:0] run_xor;
  bit         held;
  int         idle_cnt;
  int         echo_left;
  logic [7:0] tmo_reg;

  bus_frame_receiver_xor_check_unit DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_word   (in_word),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata)
  );

  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // ---------------------------------------------------------------------------
  // Predictor
  // ---------------------------------------------------------------------------

  // Forget the buffered frame; the store contents themselves stay.
  function automatic void drop_frame();
    fill_cnt = 0;
    run_xor  = '0;
    held     = 1'b0;
  endfunction

  // Housekeeping ahead of every byte or tick: release a held frame, then
  // drop a full buffer, then drop a partial frame that has sat idle too long.
  // A later discard overrides the event of an earlier one.
  function automatic event_t settle_before_word();
    event_t ev;
    ev = EV_NONE;
    if (held) drop_frame();
    if (fill_cnt >= DEPTH - 1) begin
      drop_frame();
      ev = EV_OVERFLOW;
    end
    if (fill_cnt > 0 && idle_cnt >= int'(tmo_reg)) begin
      drop_frame();
      ev = EV_TIMEOUT;
    end
    return ev;
  endfunction

  // Advance the shadow state by one accepted word and return the result
  // the block owes for it.
  function automatic out_word_t predict_frame_event(in_word_t w);
    out_word_t  r;
    event_t     ev;
    logic [7:0] rd;
    ev = EV_NONE;
    rd = '0;
    case (w.action)
      ACT_BYTE: begin
        ev = settle_before_word();
        if (echo_left > 0) begin
          // Our own transmission coming back: skip it
          echo_left--;
          ev = EV_ECHO;
        end else if (fill_cnt < DEPTH) begin
          frame_mem[fill_cnt] = w.data_byte;
          fill_cnt++;
          run_xor ^= w.data_byte;
        end
        idle_cnt = 0;
        // Complete once the count matches the length byte plus sender and length
        if (fill_cnt > MIN_FRAME_CNT && fill_cnt == int'(frame_mem[1]) + 2) begin
          if (run_xor == 8'h00) begin
            held = 1'b1;
            ev   = EV_VALID;
          end else begin
            drop_frame();
            ev = EV_BAD_SUM;
          end
        end
      end
      ACT_TICK: begin
        if (idle_cnt < IDLE_MAX) idle_cnt++;
        ev = settle_before_word();
      end
      ACT_SENT: begin
        echo_left = int'(w.echo_count);
      end
      default: begin
        if (int'(w.read_index) < DEPTH) rd = frame_mem[w.read_index];
        ev = EV_READ;
      end
    endcase
    r.event_res   = ev;
    r.frame_ready = held;
    r.byte_count  = fill_cnt[7:0];
    r.read_byte   = rd;
    return r;
  endfunction

  function automatic bit field_ok(string name, logic [7:0] want, logic [7:0] got);
    if (got !== want) begin
      $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
      return 1'b0;
    end
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: offer the next queued word, hold it while stalled
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (bus_words_todo.size() != 0 && $urandom_range(99) >= tx_idle_pct) begin
        in_valid <= 1'b1;
        in_word  <= bus_words_todo.pop_front();
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: check each result against the oldest prediction, predict each
  // accepted word, and pick the next cycle's stall.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : rx_monitor
    out_word_t want;
    if (rst_n) begin
      // Check first, so a result that races its own word is still caught
      if (out_valid && !out_stall) begin
        if (frame_events_due.size() == 0) begin
          $display("%0t ns: result %h arrived with nothing expected", $time, out_word);
          err_cnt++;
        end else begin
          want = frame_events_due.pop_front();
          if (!field_ok("event_res", 8'(want.event_res), 8'(out_word.event_res))) err_cnt++;
          if (!field_ok("frame_ready", 8'(want.frame_ready), 8'(out_word.frame_ready)))
            err_cnt++;
          if (!field_ok("byte_count", want.byte_count, out_word.byte_count)) err_cnt++;
          if (!field_ok("read_byte", want.read_byte, out_word.read_byte)) err_cnt++;
          ev_tally[want.event_res]++;
        end
      end
      if (in_valid && !in_stall) begin
        frame_events_due.push_back(predict_frame_event(in_word));
        words_taken++;
      end
      if (in_valid && in_stall) stall_cycles++;
    end
    out_stall <= rst_n && (rx_hold || $urandom_range(99) < rx_stall_pct);
  end

  // Long receiver hold-off: once released, block the output long enough for
  // the internal queue to fill and push back on the input.
  initial begin : rx_hold_off
    wait (hold_go);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    rx_hold <= 1'b0;
  end

  // Watchdog: count cycles with work outstanding but no word moving on
  // either side; give up when the count reaches the limit.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (bus_words_todo.size() == 0 && frame_events_due.size() == 0 && !in_valid)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t ns: no progress for %0d cycles, %0d results outstanding",
               $time, quiet_cycles, frame_events_due.size());
      $display("bus_frame_receiver_xor_check_unit test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------

  // Queue one word; the fields the action ignores carry random junk.
  task automatic push_word(logic [1:0] act, int val);
    in_word_t w;
    w.action     = act;
    w.data_byte  = 8'($urandom);
    w.echo_count = 9'($urandom_range(257));
    w.read_index = 8'($urandom_range(READ_MAX));
    case (act)
      ACT_BYTE: w.data_byte  = 8'(val);
      ACT_SENT: w.echo_count = 9'(val);
      ACT_READ: w.read_index = 8'(val);
      default: ;
    endcase
    bus_words_todo.push_back(w);
    words_queued++;
  endtask

  task automatic push_ticks(int n);
    repeat (n) push_word(ACT_TICK, 0);
  endtask

  // Queue a whole frame: sender, length, payload, checksum. Scatter short
  // tick runs that stay under the timeout; corrupt flips one checksum bit.
  task automatic push_frame(int len, bit corrupt);
    logic [7:0] sum;
    logic [7:0] b;
    int k;
    b   = 8'($urandom);
    sum = b;
    push_word(ACT_BYTE, b);
    sum ^= 8'(len);
    push_word(ACT_BYTE, len);
    for (k = 0; k < len - 1; k++) begin
      b = 8'($urandom);
      sum ^= b;
      push_word(ACT_BYTE, b);
      if (tmo_reg > 1 && $urandom_range(9) == 0)
        push_ticks($urandom_range(1, (tmo_reg > 4) ? 3 : int'(tmo_reg) - 1));
    end
    if (corrupt) sum ^= 8'h01 << $urandom_range(7);
    push_word(ACT_BYTE, sum);
  endtask

  // Mostly short frames, now and then a long one
  function automatic int pick_len();
    return ($urandom_range(49) == 0) ? $urandom_range(100, 253) : $urandom_range(3, 12);
  endfunction

  // Random traffic: mostly well-formed frames, with bad checksums, reads,
  // tick runs, stray bytes and echo episodes mixed in.
  task automatic push_random_traffic(int target);
    int first;
    int pick;
    int n;
    first = words_queued;
    while (words_queued - first < target) begin
      pick = $urandom_range(99);
      if (pick < 50) begin
        push_frame(pick_len(), 1'b0);
      end else if (pick < 60) begin
        push_frame(pick_len(), 1'b1);
      end else if (pick < 72) begin
        push_word(ACT_READ, $urandom_range(READ_MAX));
      end else if (pick < 82) begin
        // A tick run; with a short timeout sometimes long enough to expire
        if (tmo_reg <= 16 && $urandom_range(1) == 0) push_ticks(int'(tmo_reg));
        else push_ticks($urandom_range(1, 3));
      end else if (pick < 90) begin
        // Stray bytes, then resync by timing out when that is cheap
        repeat ($urandom_range(1, 3)) push_word(ACT_BYTE, $urandom_range(255));
        if (tmo_reg <= 16) push_ticks(int'(tmo_reg));
      end else if (pick < 97) begin
        n = $urandom_range(1, 4);
        push_word(ACT_SENT, n);
        repeat (n) push_word(ACT_BYTE, $urandom_range(255));
      end else begin
        // Huge echo count, then override it before it eats the stream
        push_word(ACT_SENT, $urandom_range(256, 257));
        push_word(ACT_SENT, ($urandom_range(3) == 0) ? 1 : 0);
      end
    end
  endtask

  // Hold the sender until every queued word has been answered.
  task automatic wait_all_reported();
    while (bus_words_todo.size() != 0 || in_valid || frame_events_due.size() != 0)
      @(posedge clk);
  endtask

  // Write the idle timeout while the block is idle; mirror it in the predictor.
  task automatic write_timeout(logic [7:0] v);
    wait_all_reported();
    repeat (DRAIN_CYCLES) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_wdata <= v;
    @(posedge clk);
    cfg_we    <= 1'b0;
    tmo_reg = v;
  endtask

  initial begin : stimulus
    int k;
    fill_cnt  = 0;
    run_xor   = '0;
    held      = 1'b0;
    idle_cnt  = 0;
    echo_left = 0;
    tmo_reg   = IDLE_TIMEOUT_RST;

    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Directed part, reset timeout, no idling on either side.
    // Fill the store up to its last usable position first, behind a length
    // byte that can never complete, so every later read hits a written entry.
    push_word(ACT_BYTE, $urandom_range(255));
    push_word(ACT_BYTE, 8'hFE);
    for (k = 0; k < DEPTH - 3; k++)
      push_word(ACT_BYTE, (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : $urandom_range(255));
    push_word(ACT_BYTE, $urandom_range(255));   // full buffer: overflow discard
    push_word(ACT_READ, 0);
    push_word(ACT_READ, READ_MAX);
    push_word(ACT_READ, 128);
    push_ticks(int'(tmo_reg));                  // partial frame times out
    push_frame(3, 1'b0);                        // shortest valid frame, held
    push_word(ACT_READ, 4);
    push_ticks(1);                              // tick releases the held frame
    push_frame(3, 1'b0);
    push_frame(3, 1'b1);                        // first byte releases, bad checksum
    push_word(ACT_SENT, 257);
    push_word(ACT_SENT, 0);
    push_word(ACT_SENT, 256);
    push_word(ACT_SENT, 2);
    push_word(ACT_BYTE, 8'hFF);                 // two echoes skipped
    push_word(ACT_BYTE, 8'h00);
    push_frame(4, 1'b0);

    // Shortest timeout, sender idling
    write_timeout(8'd1);
    tx_idle_pct  = 72;
    rx_stall_pct = 0;
    push_random_traffic(100);

    // Longest timeout, receiver stalling, with one long hold-off while the
    // sender keeps offering words
    write_timeout(8'd255);
    tx_idle_pct  = 0;
    rx_stall_pct = 72;
    push_ticks(IDLE_MAX + 5);                   // idle count saturates on an empty buffer
    push_word(ACT_BYTE, $urandom_range(255));
    push_ticks(IDLE_MAX);                       // expires exactly at the limit
    push_random_traffic(100);
    hold_go = 1'b1;

    // Zero timeout: any partial frame is dropped before the next byte
    write_timeout(8'd0);
    tx_idle_pct  = 23;
    rx_stall_pct = 23;
    push_random_traffic(60);

    // Random timeout, no idling; the sender pauses halfway until all is answered
    mid_tmo = $urandom_range(2, 254);
    write_timeout(8'(mid_tmo));
    tx_idle_pct  = 0;
    rx_stall_pct = 0;
    push_random_traffic(70);
    wait_all_reported();
    push_random_traffic(70);

    // Back to the reset timeout, both sides idling
    write_timeout(IDLE_TIMEOUT_RST);
    tx_idle_pct  = 23;
    rx_stall_pct = 23;
    push_random_traffic(190);

    wait_all_reported();
    repeat (2 * DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d words: %0d valid frames, %0d bad checksums, %0d timeouts,",
             words_taken, ev_tally[EV_VALID], ev_tally[EV_BAD_SUM], ev_tally[EV_TIMEOUT]);
    $display("%0d overflows, %0d echo skips, %0d reads; stalled %0d cycles, timeouts %0s%0d",
             ev_tally[EV_OVERFLOW], ev_tally[EV_ECHO], ev_tally[EV_READ], stall_cycles,
             "8/1/255/0/", mid_tmo);
    if (err_cnt == 0 && frame_events_due.size() == 0) begin
      $display("bus_frame_receiver_xor_check_unit test passed");
    end else begin
      $display("bus_frame_receiver_xor_check_unit test failed");
    end
    $finish;
  end

endmodule
